[hdl/rgbblit_pkg.sv]
// shared constants, register map and channel packing function for the rgb888 blit
// depends on nothing; used by rgb888_to_masked_pixel_blit
`default_nettype none

package rgbblit_pkg;

  // largest frame side and destination pitch the block handles
  localparam int MAX_DIMENSION = 4096;
  localparam int MAX_PITCH     = 65536;

  // widths of the counters and of the clamped pitch
  localparam int DIM_W    = $clog2(MAX_DIMENSION);
  localparam int PITCH_W  = $clog2(MAX_PITCH + 1);

  // widths fixed by the register and field definitions
  localparam int LAYOUT_W   = 10;
  localparam int CFG_DIM_W  = 13;
  localparam int CFG_PITCH_W = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int CHAN_W     = 8;
  localparam int WORD_W     = 32;
  localparam int OFFSET_W   = 28;

  localparam logic [4:0] MAX_FIELD_SIZE = 5'd24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_LAYOUT   = 3'd0,
    REG_GREEN_LAYOUT = 3'd1,
    REG_BLUE_LAYOUT  = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4,
    REG_ROW_PITCH    = 3'd5
  } cfg_reg_t;

  localparam logic [LAYOUT_W-1:0]    RST_RED_LAYOUT   = 10'd528;
  localparam logic [LAYOUT_W-1:0]    RST_GREEN_LAYOUT = 10'd264;
  localparam logic [LAYOUT_W-1:0]    RST_BLUE_LAYOUT  = 10'd256;
  localparam logic [CFG_DIM_W-1:0]   RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_DIM_W-1:0]   RST_FRAME_HEIGHT = 13'd480;
  localparam logic [CFG_PITCH_W-1:0] RST_ROW_PITCH    = 17'd2560;

  // whole multiple of 255 inside (2^s - 1): (2^s - 2^(s mod 8)) / 255
  function automatic logic [16:0] field_k(input logic [4:0] size);
    logic [16:0] k;
    case (size)
      5'd8:    k = 17'd1;
      5'd9:    k = 17'd2;
      5'd10:   k = 17'd4;
      5'd11:   k = 17'd8;
      5'd12:   k = 17'd16;
      5'd13:   k = 17'd32;
      5'd14:   k = 17'd64;
      5'd15:   k = 17'd128;
      5'd16:   k = 17'd257;
      5'd17:   k = 17'd514;
      5'd18:   k = 17'd1028;
      5'd19:   k = 17'd2056;
      5'd20:   k = 17'd4112;
      5'd21:   k = 17'd8224;
      5'd22:   k = 17'd16448;
      5'd23:   k = 17'd32896;
      5'd24:   k = 17'd65793;
      default: k = 17'd0;
    endcase
    return k;
  endfunction

  // rounded rescale of an 8-bit channel to its field, then placed at its position
  function automatic logic [WORD_W-1:0] place_channel(input logic [CHAN_W-1:0] v,
                                                      input logic [LAYOUT_W-1:0] layout);
    logic [4:0]  size;
    logic [4:0]  pos;
    logic [2:0]  m;
    logic [23:0] prod;
    logic [15:0] y;
    logic [15:0] q_lo;
    logic [23:0] scaled;
    size = layout[9:5];
    pos  = layout[4:0];
    if (size > MAX_FIELD_SIZE) size = MAX_FIELD_SIZE;
    m    = size[2:0];
    prod = 24'(24'(v) * 24'(field_k(size)));
    // remainder part stays below 2^15, so y/255 is a shift-add
    y    = 16'((16'(v) << m) - 16'(v) + 16'd127);
    q_lo = 16'((y + (y >> 8) + 16'd1) >> 8);
    scaled = prod + 24'(q_lo);
    return 32'(scaled) << pos;
  endfunction

endpackage

`default_nettype wire

[hdl/rgb888_to_masked_pixel_blit.sv]
// rgb888 to masked pixel converter with vertical flip: one source pixel in, one
// packed word with destination byte offset out; uses rgbblit_pkg
//
// Takes one pixel per clock while in_stall is low, bottom row first, and gives one
// result per pixel through the input register and then the result register. The
// row/column counters advance on every input transfer; each channel is scaled as
// an 8x17 multiply plus a shift-add rounding term, and the offset is a 12x17
// multiply, all between the two registers. Configuration writes are always taken
// (cfg_ready is high) and are meant for when no pixel is in flight.
`default_nettype none

module rgb888_to_masked_pixel_blit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // configuration write channel
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [rgbblit_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rgbblit_pkg::CFG_DATA_W-1:0]    cfg_data,
  // source pixels
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [rgbblit_pkg::CHAN_W-1:0]        in_red_in,
  input  wire logic [rgbblit_pkg::CHAN_W-1:0]        in_green_in,
  input  wire logic [rgbblit_pkg::CHAN_W-1:0]        in_blue_in,
  // packed pixels
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [rgbblit_pkg::WORD_W-1:0]             out_pixel_word,
  output logic [rgbblit_pkg::OFFSET_W-1:0]           out_byte_offset,
  output logic                                       out_frame_end
);

  localparam int DIM_W   = rgbblit_pkg::DIM_W;
  localparam int PITCH_W = rgbblit_pkg::PITCH_W;
  localparam int PROD_W  = DIM_W + PITCH_W;

  // configuration registers
  logic [rgbblit_pkg::LAYOUT_W-1:0]    red_layout_r, green_layout_r, blue_layout_r;
  logic [rgbblit_pkg::CFG_DIM_W-1:0]   frame_width_r, frame_height_r;
  logic [rgbblit_pkg::CFG_PITCH_W-1:0] row_pitch_r;

  // frame counters
  logic [DIM_W-1:0] column_r, column_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;

  // input stage
  logic                             s1_valid_r, s1_valid_nxt;
  logic [rgbblit_pkg::CHAN_W-1:0]   s1_red_r, s1_green_r, s1_blue_r;
  logic [DIM_W-1:0]                 s1_col_r, s1_flip_r;
  logic                             s1_end_r;

  // result stage
  logic out_valid_r, out_valid_nxt;
  logic [rgbblit_pkg::WORD_W-1:0]   word_r, word_nxt;
  logic [rgbblit_pkg::OFFSET_W-1:0] offset_r, offset_nxt;
  logic                             end_r;

  logic             in_fire, out_fire, out_load;
  logic [DIM_W-1:0] wm1, hm1, flip;
  logic             last_col, last_row;
  logic [PITCH_W-1:0] pitch;
  logic [PROD_W-1:0]  offset_full;

  // last index of a side: zero reads as one, large values saturate
  function automatic logic [DIM_W-1:0] dim_last(input logic [rgbblit_pkg::CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > rgbblit_pkg::MAX_DIMENSION) begin
      r = DIM_W'(rgbblit_pkg::MAX_DIMENSION - 1);
    end else begin
      r = DIM_W'(v - 1'b1);
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_layout_r   <= rgbblit_pkg::RST_RED_LAYOUT;
      green_layout_r <= rgbblit_pkg::RST_GREEN_LAYOUT;
      blue_layout_r  <= rgbblit_pkg::RST_BLUE_LAYOUT;
      frame_width_r  <= rgbblit_pkg::RST_FRAME_WIDTH;
      frame_height_r <= rgbblit_pkg::RST_FRAME_HEIGHT;
      row_pitch_r    <= rgbblit_pkg::RST_ROW_PITCH;
    end else if (cfg_valid && cfg_ready) begin
      case (rgbblit_pkg::cfg_reg_t'(cfg_index))
        rgbblit_pkg::REG_RED_LAYOUT:   red_layout_r   <= cfg_data[rgbblit_pkg::LAYOUT_W-1:0];
        rgbblit_pkg::REG_GREEN_LAYOUT: green_layout_r <= cfg_data[rgbblit_pkg::LAYOUT_W-1:0];
        rgbblit_pkg::REG_BLUE_LAYOUT:  blue_layout_r  <= cfg_data[rgbblit_pkg::LAYOUT_W-1:0];
        rgbblit_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[rgbblit_pkg::CFG_DIM_W-1:0];
        rgbblit_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[rgbblit_pkg::CFG_DIM_W-1:0];
        rgbblit_pkg::REG_ROW_PITCH:    row_pitch_r    <= cfg_data[rgbblit_pkg::CFG_PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: result register frees when empty or taken, input stage follows
  assign out_fire = out_valid_r && !out_stall;
  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_load;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    wm1      = dim_last(frame_width_r);
    hm1      = dim_last(frame_height_r);
    last_col = column_r >= wm1;
    last_row = row_r >= hm1;
    flip     = last_row ? '0 : DIM_W'(hm1 - row_r);

    column_nxt = column_r;
    row_nxt    = row_r;
    if (in_fire) begin
      if (last_col) begin
        column_nxt = '0;
        row_nxt    = last_row ? '0 : DIM_W'(row_r + 1'b1);
      end else begin
        column_nxt = DIM_W'(column_r + 1'b1);
      end
    end

    s1_valid_nxt = in_fire ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_load ? 1'b1 : (out_fire ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      column_r    <= column_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_red_r   <= in_red_in;
      s1_green_r <= in_green_in;
      s1_blue_r  <= in_blue_in;
      s1_col_r   <= column_r;
      s1_flip_r  <= flip;
      s1_end_r   <= last_col && last_row;
    end
  end

  // packing and offset arithmetic between the two registers
  always_comb begin
    if (32'(row_pitch_r) > rgbblit_pkg::MAX_PITCH) begin
      pitch = PITCH_W'(rgbblit_pkg::MAX_PITCH);
    end else begin
      pitch = PITCH_W'(row_pitch_r);
    end
    offset_full = PROD_W'(PROD_W'(s1_flip_r) * PROD_W'(pitch))
                + (PROD_W'(s1_col_r) << 2);
    offset_nxt  = offset_full[rgbblit_pkg::OFFSET_W-1:0];
    word_nxt    = rgbblit_pkg::place_channel(s1_red_r, red_layout_r)
                | rgbblit_pkg::place_channel(s1_green_r, green_layout_r)
                | rgbblit_pkg::place_channel(s1_blue_r, blue_layout_r);
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      word_r   <= word_nxt;
      offset_r <= offset_nxt;
      end_r    <= s1_end_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_word  = word_r;
  assign out_byte_offset = offset_r;
  assign out_frame_end   = end_r;

  // the column counter wraps to zero after the last column
  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last_col |=> column_r == '0)
    else $error("column counter did not wrap at end of row");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !last_col |=> column_r == DIM_W'($past(column_r) + 1'b1))
    else $error("column counter did not advance on transfer");

  // the last pixel of a frame always lands in the top destination row
  a_end_top: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_end_r |-> s1_flip_r == '0)
    else $error("frame end flagged off the top destination row");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_load |=> s1_valid_r)
    else $error("input stage dropped a pixel");

endmodule

`default_nettype wire
